### src/calu_pkg.sv
// ----------------------------------------------------------------------------
// calu_pkg: shared types and constants for the 8-bit ALU
// Holds the operation codes, the input item and the result record.
// ----------------------------------------------------------------------------
package calu_pkg;

    // Operation codes. Codes 11 to 15 are unused and flagged as bad.
    typedef enum logic [3:0] {
        OP_ADD8      = 4'd0,
        OP_SUB8      = 4'd1,
        OP_ADD16_LO  = 4'd2,
        OP_ADD16_HI  = 4'd3,
        OP_SHL       = 4'd4,
        OP_SHR       = 4'd5,
        OP_SRA       = 4'd6,
        OP_ROL       = 4'd7,
        OP_ROR       = 4'd8,
        OP_RLC       = 4'd9,
        OP_RRC       = 4'd10
    } t_op;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic        carry_in;
    } t_item;

    typedef struct packed {
        logic [15:0] value;
        logic        zero;
        logic        subtract;
        logic        half;
        logic        carry;
        logic        bad;
    } t_result;

endpackage

### src/calu_core.sv
// ----------------------------------------------------------------------------
// calu_core: ALU datapath
// Works out the value, the Z, N, H and C flags and the bad-code flag of one operation.
// ----------------------------------------------------------------------------
module calu_core (
    input  calu_pkg::t_item   i_item,
    output calu_pkg::t_result o_result
);

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        ci;
    logic [8:0]  sum8;
    logic [4:0]  hsum8;
    logic [8:0]  dif8;
    logic [4:0]  hdif8;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [4:0]  nib16;
    logic [8:0]  low16;

    always_comb begin
        a8    = i_item.operand_a[7:0] & calu_pkg::BYTE_MASK;
        b8    = i_item.operand_b[7:0] & calu_pkg::BYTE_MASK;
        ci    = i_item.carry_in;

        // Carry and borrow chains; the top bit of each is the carry or borrow out.
        sum8  = {1'b0, a8} + {1'b0, b8} + {8'd0, ci};
        hsum8 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, ci};
        dif8  = {1'b0, a8} - {1'b0, b8} - {8'd0, ci};
        hdif8 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, ci};
        sum16 = {1'b0, i_item.operand_a} + {1'b0, i_item.operand_b};
        sum12 = {1'b0, i_item.operand_a[11:0]} + {1'b0, i_item.operand_b[11:0]};
        nib16 = {1'b0, i_item.operand_a[3:0]} + {1'b0, i_item.operand_b[3:0]};
        low16 = {1'b0, a8} + {1'b0, b8};

        o_result = '0;

        unique case (calu_pkg::t_op'(i_item.operation))
            calu_pkg::OP_ADD8: begin
                o_result.value = {8'd0, sum8[7:0]};
                o_result.half  = hsum8[4];
                o_result.carry = sum8[8];
            end
            calu_pkg::OP_SUB8: begin
                o_result.value    = {8'd0, dif8[7:0]};
                o_result.subtract = 1'b1;
                o_result.half     = hdif8[4];
                o_result.carry    = dif8[8];
            end
            calu_pkg::OP_ADD16_LO: begin
                o_result.value = sum16[15:0];
                o_result.half  = nib16[4];
                o_result.carry = low16[8];
            end
            calu_pkg::OP_ADD16_HI: begin
                o_result.value = sum16[15:0];
                o_result.half  = sum12[12];
                o_result.carry = sum16[16];
            end
            calu_pkg::OP_SHL: begin
                o_result.value = {8'd0, a8[6:0], 1'b0};
                o_result.carry = a8[7];
            end
            calu_pkg::OP_SHR: begin
                o_result.value = {8'd0, 1'b0, a8[7:1]};
                o_result.carry = a8[0];
            end
            calu_pkg::OP_SRA: begin
                o_result.value = {8'd0, a8[7], a8[7:1]};
                o_result.carry = a8[0];
            end
            calu_pkg::OP_ROL: begin
                o_result.value = {8'd0, a8[6:0], a8[7]};
                o_result.carry = a8[7];
            end
            calu_pkg::OP_ROR: begin
                o_result.value = {8'd0, a8[0], a8[7:1]};
                o_result.carry = a8[0];
            end
            calu_pkg::OP_RLC: begin
                o_result.value = {8'd0, a8[6:0], ci};
                o_result.carry = a8[7];
            end
            calu_pkg::OP_RRC: begin
                o_result.value = {8'd0, ci, a8[7:1]};
                o_result.carry = a8[0];
            end
            default: begin
                o_result.bad = 1'b1;
            end
        endcase

        o_result.zero = !o_result.bad && (o_result.value == 16'd0);
    end

endmodule

### src/cpu_alu_8bit_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_flags: pipelined 8-bit ALU with Z, N, H and C flags
// An input register, the ALU datapath and a result register; each register
// holds one beat, so one operation can enter on every clock while out is not stalled.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ------------------------------
//  in       into ALU   i_in_valid / o_in_ready    operation, operands, carry-in
//  out      from ALU   o_out_valid / i_out_ready  value, Z, N, H, C, bad code
//
// A beat accepted on the in channel is captured in the input register, passes
// through the datapath and is captured in the result register, from which it
// is presented on the out channel; a stall on that channel can hold it back.
// With the output taken on every cycle the block sustains one beat per cycle;
// the throughput is set by the two stage registers, each of which refills in
// the cycle it empties.
// A stall on the out channel holds the result register; the input register
// then fills behind it, and only when both hold a beat does o_in_ready fall.
// The synchronous, active-low reset empties both stages; no payload is reset.
//
module cpu_alu_8bit_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_operation,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic        i_carry_in,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_value,
    output logic        o_flag_zero,
    output logic        o_flag_subtract,
    output logic        o_flag_half,
    output logic        o_flag_carry,
    output logic        o_bad_operation
);

    // Stage occupancy and payload registers.
    logic                r_in_valid;
    logic                n_in_valid;
    calu_pkg::t_item     r_in_item;
    logic                r_out_valid;
    logic                n_out_valid;
    calu_pkg::t_result   r_out_res;

    logic                out_stage_ready;
    logic                in_take;
    logic                out_take;
    calu_pkg::t_result   core_res;

    // The datapath works on whatever the input register holds.
    calu_core u_core (
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    // Each stage may load when it is empty or when its beat leaves this cycle.
    always_comb begin
        out_stage_ready = !r_out_valid || i_out_ready;
        o_in_ready      = !r_in_valid || out_stage_ready;
        in_take         = i_in_valid && o_in_ready;
        out_take        = r_in_valid && out_stage_ready;
        n_in_valid      = o_in_ready ? i_in_valid : r_in_valid;
        n_out_valid     = out_stage_ready ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.operation <= i_operation;
            r_in_item.operand_a <= i_operand_a;
            r_in_item.operand_b <= i_operand_b;
            r_in_item.carry_in  <= i_carry_in;
        end
        if (out_take) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_value         = r_out_res.value;
    assign o_flag_zero     = r_out_res.zero;
    assign o_flag_subtract = r_out_res.subtract;
    assign o_flag_half     = r_out_res.half;
    assign o_flag_carry    = r_out_res.carry;
    assign o_bad_operation = r_out_res.bad;

`ifndef SYNTHESIS
    // An unused code must present an all-zero result.
    a_bad_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_operation) |->
            (o_value == 16'd0 && !o_flag_zero && !o_flag_subtract &&
             !o_flag_half && !o_flag_carry))
        else $error("bad operation with non-zero result");

    // Z must agree with the value for every used code.
    a_zero_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_bad_operation) |-> (o_flag_zero == (o_value == 16'd0)))
        else $error("zero flag disagrees with value");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

    // A beat in the input stage moves on when the result register is free.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_stage_ready) |=> r_out_valid)
        else $error("beat lost between stages");

    // A result held under stall keeps the upstream side from losing a beat.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages full and stalled");
`endif

endmodule
